### rtl/core/pmu_pkg.sv
// ----------------------------------------------------------------------------
// pmu_pkg: shared types and constants of the polynomial multiplier unit
// Holds the request and result structs, command codes, the FSM state type
// and the widths used by the cell chain.
// ----------------------------------------------------------------------------
package pmu_pkg;

  // Number of coefficient slots in each operand store.
  localparam int MAX_TERMS = 32;
  // Coefficient precision kept in the stores.
  localparam int COEF_BITS = 8;

  // Fixed field widths of the request and result.
  localparam int CMD_W      = 2;
  localparam int POW_IN_W   = 5;
  localparam int COEF_IN_W  = 8;
  localparam int OUT_COEF_W = 21;
  localparam int POW_OUT_W  = 6;

  // Stored coefficient width: the request field never carries more than 8 bits.
  localparam int KBITS = (COEF_BITS < COEF_IN_W) ? COEF_BITS : COEF_IN_W;
  // Partial sum width: one product plus growth over all taps.
  localparam int ACC_W = 2 * KBITS + $clog2(MAX_TERMS);

  // Emit sweep: one step per product term plus one to drain the chain.
  localparam int STEP_W    = $clog2(2 * MAX_TERMS);
  localparam int LAST_STEP = 2 * MAX_TERMS - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_EMIT   = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic [POW_IN_W-1:0]         power;
    logic signed [COEF_IN_W-1:0] coefficient;
  } cmd_req_t;

  typedef struct packed {
    logic signed [OUT_COEF_W-1:0] product_coefficient;
    logic [POW_OUT_W-1:0]         product_power;
    logic                         last;
    logic                         all_zero;
  } res_rsp_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic clear;
  } cell_ctl_t;

endpackage

### rtl/core/pmu_cell.sv
// ----------------------------------------------------------------------------
// pmu_cell: one tap of the convolution chain
// Holds one A coefficient, one B coefficient and one partial sum. On a step
// it multiplies its A value by the broadcast B sample, adds the partial sum
// of its right neighbor and passes its own B value to its left neighbor.
// ----------------------------------------------------------------------------
module pmu_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  pmu_pkg::cell_ctl_t                  ctl,
  input  logic signed [pmu_pkg::KBITS-1:0]    coef_in,
  input  logic signed [pmu_pkg::KBITS-1:0]    sample,
  input  logic signed [pmu_pkg::KBITS-1:0]    b_in,
  output logic signed [pmu_pkg::KBITS-1:0]    b_out,
  input  logic signed [pmu_pkg::ACC_W-1:0]    sum_in,
  output logic signed [pmu_pkg::ACC_W-1:0]    sum_out
);
  import pmu_pkg::*;

  logic signed [KBITS-1:0]   a_coef;
  logic signed [KBITS-1:0]   b_coef;
  logic signed [ACC_W-1:0]   sum;
  logic signed [2*KBITS-1:0] product;
  logic signed [ACC_W-1:0]   sum_next;

  // Tap product and accumulation with the neighbor's partial sum.
  always_comb begin
    product  = a_coef * sample;
    sum_next = ACC_W'(product) + sum_in;
  end

  // Store and chain registers; clear empties both stores after an emit.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      a_coef <= '0;
      b_coef <= '0;
      sum    <= '0;
    end else begin
      if (ctl.load_a) begin
        a_coef <= coef_in;
      end
      if (ctl.load_b) begin
        b_coef <= coef_in;
      end
      if (ctl.step) begin
        b_coef <= b_in;
        sum    <= sum_next;
      end
    end
  end

  assign b_out   = b_coef;
  assign sum_out = sum;

endmodule

### rtl/core/polynomial_multiplier_unit.sv
// ----------------------------------------------------------------------------
// polynomial_multiplier_unit: exact integer product of two polynomials
// Loads coefficients of A and B into a chain of tap cells and, on an emit
// request, streams the product highest power first through a result register.
//
//   Channel  Handshake              Payload    Carries
//   cmd      cmd_valid/cmd_ready    cmd_req_t  load A, load B or emit request
//   res      res_valid/res_ready    res_rsp_t  one product coefficient
//
// An emit request runs 2*MAX_TERMS steps through the transposed tap chain,
// one product term per step after the first (leading zero terms are skipped),
// and the next request is taken after that. Output stalls freeze the chain.
// Reset is synchronous and clears both stores; the stores are cleared again
// at the end of an emit.
// ----------------------------------------------------------------------------
module polynomial_multiplier_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  pmu_pkg::cmd_req_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output pmu_pkg::res_rsp_t res
);
  import pmu_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [STEP_W-1:0]       step_cnt;
  logic [STEP_W-1:0]       step_cnt_next;
  logic                    seen;
  logic                    seen_next;
  logic                    res_valid_next;
  res_rsp_t                res_next;

  logic                    accept;
  logic                    step;
  logic                    final_step;
  logic                    nonzero;
  logic signed [KBITS-1:0] coef_k;
  cell_ctl_t               ctl [MAX_TERMS];
  logic signed [KBITS-1:0] b_chain [MAX_TERMS+1];
  logic signed [ACC_W-1:0] sum_chain [MAX_TERMS+1];

  assign accept     = cmd_valid && cmd_ready;
  assign step       = (state == ST_EMIT) && (!res_valid || res_ready);
  assign final_step = step && (step_cnt == STEP_W'(LAST_STEP));
  assign coef_k     = KBITS'(cmd.coefficient);
  assign nonzero    = (sum_chain[0] != '0);

  // Zeros enter at the far end of both chains.
  assign b_chain[MAX_TERMS]   = '0;
  assign sum_chain[MAX_TERMS] = '0;

  // Cell d holds the coefficients of power MAX_TERMS-1-d.
  always_comb begin
    for (int d = 0; d < MAX_TERMS; d++) begin
      ctl[d].load_a = accept && (cmd.command == CMD_LOAD_A) &&
                      (cmd.power == POW_IN_W'(MAX_TERMS - 1 - d));
      ctl[d].load_b = accept && (cmd.command == CMD_LOAD_B) &&
                      (cmd.power == POW_IN_W'(MAX_TERMS - 1 - d));
      ctl[d].step   = step;
      ctl[d].clear  = final_step;
    end
  end

  // Tap chain; cell 0 supplies the broadcast B sample and the finished term.
  for (genvar d = 0; d < MAX_TERMS; d++) begin : g_cell
    pmu_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[d]),
      .coef_in (coef_k),
      .sample  (b_chain[0]),
      .b_in    (b_chain[d+1]),
      .b_out   (b_chain[d]),
      .sum_in  (sum_chain[d+1]),
      .sum_out (sum_chain[d])
    );
  end

  // Sequencer and result register control.
  always_comb begin
    state_next     = state;
    step_cnt_next  = step_cnt;
    seen_next      = seen;
    res_valid_next = res_valid && !res_ready;
    res_next       = res;
    cmd_ready      = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (accept && (cmd.command == CMD_EMIT)) begin
          state_next    = ST_EMIT;
          step_cnt_next = '0;
          seen_next     = 1'b0;
        end
      end
      ST_EMIT: begin
        if (step) begin
          step_cnt_next = step_cnt + 1'b1;
          // From the second step on, cell 0 holds the term of power LAST_STEP-step_cnt.
          if (step_cnt != '0) begin
            seen_next = seen || nonzero;
            if (nonzero || seen || final_step) begin
              res_valid_next               = 1'b1;
              res_next.product_coefficient = OUT_COEF_W'(sum_chain[0]);
              res_next.product_power       = POW_OUT_W'(STEP_W'(LAST_STEP) - step_cnt);
              res_next.last                = final_step;
              res_next.all_zero            = final_step && !seen && !nonzero;
            end
          end
          if (final_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      seen      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      seen      <= seen_next;
      res_valid <= res_valid_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule
